>>> sv/iss_pkg.sv
// Shared types and constants for the indexed sequence store.
package iss_pkg;

   typedef enum logic [3:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_POP_FRONT  = 4'd2,
      OP_POP_BACK   = 4'd3,
      OP_READ_AT    = 4'd4,
      OP_WRITE_AT   = 4'd5,
      OP_INSERT_AT  = 4'd6,
      OP_REMOVE_AT  = 4'd7,
      OP_DELETE_ALL = 4'd8,
      OP_FIND_FIRST = 4'd9
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam int REQ_W = 48;
   localparam int RSP_W = 128;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_GRAB,
      S_LOOP,
      S_PUT,
      S_FRONT,
      S_BACK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic grab;
      logic step;
      logic put;
      logic rd_front;
      logic rd_back;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       err;
      logic       loop_done;
      logic       out_free;
   } stat_type;

endpackage

>>> sv/iss_ctrl.sv
// Sequencing state machine for the indexed sequence store.
module iss_ctrl
   import iss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.err) begin
               state_in = S_FRONT;
            end else begin
               case (stat.op)
                  OP_POP_FRONT, OP_POP_BACK, OP_READ_AT: state_in = S_GRAB;
                  OP_PUSH_FRONT, OP_INSERT_AT, OP_REMOVE_AT,
                  OP_DELETE_ALL, OP_FIND_FIRST: state_in = S_LOOP;
                  default: state_in = S_FRONT;
               endcase
            end
         end
         S_GRAB: begin
            if (stat.op == OP_POP_FRONT) state_in = S_LOOP;
            else state_in = S_FRONT;
         end
         S_LOOP: begin
            if (stat.loop_done) state_in = S_PUT;
         end
         S_PUT:   state_in = S_FRONT;
         S_FRONT: state_in = S_BACK;
         S_BACK:  state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_CHECK: cmd.check    = 1'b1;
         S_GRAB:  cmd.grab     = 1'b1;
         S_LOOP:  cmd.step     = 1'b1;
         S_PUT:   cmd.put      = 1'b1;
         S_FRONT: cmd.rd_front = 1'b1;
         S_BACK:  cmd.rd_back  = 1'b1;
         S_DONE:  cmd.finish   = stat.out_free;
         default: cmd          = '0;
      endcase
   end

endmodule

>>> sv/iss_dp.sv
// Datapath of the indexed sequence store: entry memory, count, sweep pointers, result register.
module iss_dp
   import iss_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [3:0]         req_opcode,
   input  logic [7:0]         req_position,
   input  logic [31:0]        req_operand,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 9) ? CW : 9;

   logic [31:0]      entries_ff [CAPACITY];
   logic [31:0]      rdata_ff;

   logic [3:0]       op_ff, op_in;
   logic [7:0]       pos_ff, pos_in;
   logic [31:0]      val_ff, val_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [CW-1:0]    w_ff, w_in;
   logic [AW-1:0]    rp_ff, rp_in;
   logic [AW-1:0]    pa_ff, pa_in;
   logic             pv_ff, pv_in;
   logic [31:0]      res_ff, res_in;
   logic [8:0]       found_ff, found_in;
   logic [8:0]       removed_ff, removed_in;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      front_ff, front_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [XW-1:0]    cnt_x, pos_x, pa_x, rem_x;
   logic [AW-1:0]    cnt_m1;
   logic             full, empty, err, up_op, down_op;
   logic [1:0]       err_code;
   logic             re, we;
   logic [AW-1:0]    ra, wa;
   logic [31:0]      wd;
   logic [31:0]      back_v;

   assign cnt_x  = XW'(count_ff);
   assign pos_x  = XW'(pos_ff);
   assign pa_x   = XW'(pa_ff);
   assign rem_x  = XW'(count_ff - w_ff);
   assign cnt_m1 = AW'(count_ff - CW'(1));
   assign full   = (cnt_x == XW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign up_op   = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_INSERT_AT);
   assign down_op = (op_ff == OP_POP_FRONT) || (op_ff == OP_REMOVE_AT);

   always_comb begin
      case (op_ff)
         OP_PUSH_BACK, OP_PUSH_FRONT: err_code = full ? ST_FULL : ST_OK;
         OP_POP_FRONT, OP_POP_BACK:   err_code = empty ? ST_RANGE : ST_OK;
         OP_READ_AT, OP_WRITE_AT, OP_REMOVE_AT:
            err_code = (pos_x >= cnt_x) ? ST_RANGE : ST_OK;
         OP_INSERT_AT:
            err_code = full ? ST_FULL : ((pos_x > cnt_x) ? ST_RANGE : ST_OK);
         default: err_code = ST_OK;
      endcase
   end
   assign err = (err_code != ST_OK);

   assign stat.op        = op_ff;
   assign stat.err       = err;
   assign stat.loop_done = (left_ff == '0) && !pv_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // read port
   always_comb begin
      re = 1'b0;
      ra = '0;
      priority if (cmd.check && !err) begin
         if (op_ff == OP_READ_AT) begin
            re = 1'b1;
            ra = pos_x[AW-1:0];
         end else if (op_ff == OP_POP_BACK) begin
            re = 1'b1;
            ra = cnt_m1;
         end else if (op_ff == OP_POP_FRONT) begin
            re = 1'b1;
         end
      end else if (cmd.step && (left_ff != '0)) begin
         re = 1'b1;
         ra = rp_ff;
      end else if (cmd.rd_front) begin
         re = 1'b1;
      end else if (cmd.rd_back) begin
         re = 1'b1;
         ra = cnt_m1;
      end
   end

   // write port
   always_comb begin
      we = 1'b0;
      wa = '0;
      wd = val_ff;
      priority if (cmd.check && !err) begin
         if (op_ff == OP_PUSH_BACK) begin
            we = 1'b1;
            wa = count_ff[AW-1:0];
         end else if (op_ff == OP_WRITE_AT) begin
            we = 1'b1;
            wa = pos_x[AW-1:0];
         end
      end else if (cmd.step && pv_ff) begin
         wd = rdata_ff;
         if (up_op) begin
            we = 1'b1;
            wa = pa_ff + AW'(1);
         end else if (down_op) begin
            we = 1'b1;
            wa = pa_ff - AW'(1);
         end else if (op_ff == OP_DELETE_ALL && rdata_ff != val_ff) begin
            we = 1'b1;
            wa = w_ff[AW-1:0];
         end
      end else if (cmd.put && up_op) begin
         we = 1'b1;
         wa = pos_x[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) entries_ff[wa] <= wd;
      if (re) rdata_ff <= entries_ff[ra];
   end

   assign back_v = empty ? 32'd0 : rdata_ff;

   always_comb begin
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      w_in         = w_ff;
      rp_in        = rp_ff;
      pa_in        = pa_ff;
      pv_in        = pv_ff;
      res_in       = res_ff;
      found_in     = found_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      front_in     = front_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         op_in      = req_opcode;
         pos_in     = (req_opcode == OP_PUSH_FRONT || req_opcode == OP_POP_FRONT) ?
                      8'd0 : req_position;
         val_in     = req_operand;
         res_in     = '0;
         found_in   = '0;
         removed_in = '0;
         status_in  = ST_OK;
      end

      if (cmd.check) begin
         status_in = err_code;
         pv_in     = 1'b0;
         w_in      = '0;
         left_in   = '0;
         if (!err) begin
            case (op_ff)
               OP_PUSH_BACK: count_in = count_ff + CW'(1);
               OP_PUSH_FRONT, OP_INSERT_AT: begin
                  left_in = CW'(cnt_x - pos_x);
                  rp_in   = cnt_m1;
               end
               OP_POP_FRONT, OP_REMOVE_AT: begin
                  left_in = CW'(cnt_x - pos_x - XW'(1));
                  rp_in   = AW'(pos_x + XW'(1));
               end
               OP_DELETE_ALL: begin
                  left_in = count_ff;
                  rp_in   = '0;
               end
               OP_FIND_FIRST: begin
                  left_in   = count_ff;
                  rp_in     = '0;
                  found_in  = '1;
                  status_in = ST_NOTFOUND;
               end
               default: left_in = '0;
            endcase
         end
      end

      if (cmd.grab) begin
         res_in = rdata_ff;
         if (op_ff == OP_POP_BACK) count_in = count_ff - CW'(1);
      end

      if (cmd.step) begin
         if (left_ff != '0) begin
            left_in = left_ff - CW'(1);
            pv_in   = 1'b1;
            pa_in   = rp_ff;
            rp_in   = up_op ? rp_ff - AW'(1) : rp_ff + AW'(1);
         end else begin
            pv_in = 1'b0;
         end
         if (pv_ff) begin
            if (op_ff == OP_DELETE_ALL && rdata_ff != val_ff) w_in = w_ff + CW'(1);
            if (op_ff == OP_FIND_FIRST && rdata_ff == val_ff &&
                status_ff == ST_NOTFOUND) begin
               found_in  = pa_x[8:0];
               status_in = ST_OK;
            end
         end
      end

      if (cmd.put) begin
         if (up_op) count_in = count_ff + CW'(1);
         else if (down_op) count_in = count_ff - CW'(1);
         else if (op_ff == OP_DELETE_ALL) begin
            count_in   = w_ff;
            removed_in = rem_x[8:0];
            status_in  = (count_ff == w_ff) ? ST_NOTFOUND : ST_OK;
         end
      end

      if (cmd.rd_back) front_in = empty ? 32'd0 : rdata_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, back_v, front_ff, empty, cnt_x[8:0], status_ff,
                         removed_ff, found_ff, res_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pv_ff        <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      w_ff        <= w_in;
      rp_ff       <= rp_in;
      pa_ff       <= pa_in;
      res_ff      <= res_in;
      found_ff    <= found_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
      front_ff    <= front_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished transaction not presented");

   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && err) |=> (count_ff == $past(count_ff)))
      else $error("rejected transaction changed the count");

   a_compact_ptr: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && pv_ff) |-> (w_ff <= count_ff))
      else $error("compaction write pointer past count");

endmodule

>>> sv/indexed_sequence_store.sv
// Top level of the indexed sequence store: bounded ordered list of signed words.
//
//   channel | dir | handshake           | tdata fields (low bit up)
//   req_    | in  | req_tvalid/tready   | opcode[3:0] position[11:4] operand_value[43:12]
//   rsp_    | out | rsp_tvalid/tready   | result_value, found_index, removed_count,
//           |     |                     | status, entry_count, is_empty, front, back
//
// One transaction at a time; pops and reads add a grab step. Insert, remove,
// push_front, pop_front, delete_all and find_first also sweep the entries through
// the memory's separate read and write ports, then drain, exit the loop and write
// the result back.
// Synchronous reset clears count and control; entry memory is not cleared.
// A held result does not block the next request from being accepted.
module indexed_sequence_store
   import iss_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // opcode, position, operand_value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // result_value, found_index, removed_count,
                                         // status, entry_count, is_empty,
                                         // front_value, back_value
);

   cmd_type  cmd;
   stat_type stat;

   iss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   iss_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_opcode   (req_tdata[3:0]),
      .req_position (req_tdata[11:4]),
      .req_operand  (req_tdata[43:12]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

>>> tb/indexed_sequence_store_tb.sv
// Testbench for the indexed sequence store: directed and random list operations checked against a behavioural list.
`timescale 1ns / 1ps
module indexed_sequence_store_tb;
   import iss_pkg::*;

   localparam int CAP = 256;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [31:0] back_value;
      logic [31:0] front_value;
      logic        is_empty;
      logic [8:0]  entry_count;
      logic [1:0]  status;
      logic [8:0]  removed_count;
      logic [8:0]  found_index;
      logic [31:0] result_value;
   } outcome_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // opcode, position, operand_value
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // result_value, found_index, removed_count,
                                       // status, entry_count, is_empty, front, back

   logic [31:0] list_words [CAP];
   int          list_len;
   outcome_t    pending_outcomes [$];
   int          mismatches = 0;
   longint      cycles = 0;
   bit          hold_off;

   indexed_sequence_store #(.CAPACITY(CAP)) DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("indexed_sequence_store_tb: FAIL");
         $finish;
      end
   end

   function automatic outcome_t apply_op(logic [3:0] op, logic [7:0] pos, logic [31:0] val);
      outcome_t o;
      int w;
      o = '0;
      o.status = ST_OK;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (list_len >= CAP) o.status = ST_FULL;
            else begin
               if (op == OP_PUSH_BACK) list_words[list_len] = val;
               else begin
                  for (int k = list_len; k > 0; k--) list_words[k] = list_words[k-1];
                  list_words[0] = val;
               end
               list_len++;
            end
         end
         OP_POP_FRONT: begin
            if (list_len == 0) o.status = ST_RANGE;
            else begin
               o.result_value = list_words[0];
               for (int k = 0; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
               list_len--;
            end
         end
         OP_POP_BACK: begin
            if (list_len == 0) o.status = ST_RANGE;
            else begin
               o.result_value = list_words[list_len-1];
               list_len--;
            end
         end
         OP_READ_AT: begin
            if (pos >= list_len) o.status = ST_RANGE;
            else o.result_value = list_words[pos];
         end
         OP_WRITE_AT: begin
            if (pos >= list_len) o.status = ST_RANGE;
            else list_words[pos] = val;
         end
         OP_INSERT_AT: begin
            if (list_len >= CAP) o.status = ST_FULL;
            else if (pos > list_len) o.status = ST_RANGE;
            else begin
               for (int k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
               list_words[pos] = val;
               list_len++;
            end
         end
         OP_REMOVE_AT: begin
            if (pos >= list_len) o.status = ST_RANGE;
            else begin
               for (int k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
               list_len--;
            end
         end
         OP_DELETE_ALL: begin
            w = 0;
            for (int k = 0; k < list_len; k++)
               if (list_words[k] != val) begin
                  list_words[w] = list_words[k];
                  w++;
               end
            o.removed_count = 9'(list_len - w);
            list_len = w;
            if (o.removed_count == 0) o.status = ST_NOTFOUND;
         end
         OP_FIND_FIRST: begin
            o.found_index = 9'h1FF;
            o.status = ST_NOTFOUND;
            for (int k = 0; k < list_len; k++)
               if (list_words[k] == val) begin
                  o.found_index = 9'(k);
                  o.status = ST_OK;
                  break;
               end
         end
         default: ;
      endcase
      o.entry_count = 9'(list_len);
      o.is_empty = (list_len == 0);
      o.front_value = (list_len == 0) ? 32'd0 : list_words[0];
      o.back_value = (list_len == 0) ? 32'd0 : list_words[list_len-1];
      return o;
   endfunction

   // valid stays up after acceptance; drain_results drops it, the next call only when it waits a gap
   task automatic send_request(logic [3:0] op, logic [7:0] pos, logic [31:0] val);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {4'd0, val, pos, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes.push_back(apply_op(op, pos, val));
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_tready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      outcome_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = outcome_t'(rsp_tdata[$bits(outcome_t)-1:0]);
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_outcomes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h got %h", want, got);
            end
         end
      end
   end

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return $urandom;
         default: return 32'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic test_empty_cases();
      send_request(OP_POP_FRONT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_READ_AT, 0, 0);
      send_request(OP_WRITE_AT, 0, 5);
      send_request(OP_REMOVE_AT, 0, 0);
      send_request(OP_DELETE_ALL, 0, 1);
      send_request(OP_FIND_FIRST, 0, 1);
      send_request(OP_INSERT_AT, 1, 1);
   endtask

   task automatic test_each_operation();
      send_request(OP_PUSH_BACK, 0, 32'h7FFF_FFFF);
      send_request(OP_PUSH_FRONT, 0, 32'h8000_0000);
      send_request(OP_INSERT_AT, 2, 32'hFFFF_FFFF);
      send_request(OP_INSERT_AT, 0, 32'h7FFF_FFFF);
      send_request(OP_READ_AT, 8'hFF, 0);
      send_request(OP_READ_AT, 1, 0);
      send_request(OP_WRITE_AT, 3, 32'h5555_AAAA);
      send_request(OP_FIND_FIRST, 0, 32'h7FFF_FFFF);
      send_request(OP_DELETE_ALL, 0, 32'h7FFF_FFFF);
      send_request(OP_REMOVE_AT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_POP_FRONT, 0, 0);
      send_request(4'd10, 8'hAA, 32'hFFFF_FFFF);
      send_request(4'd15, 8'h55, 0);
   endtask

   task automatic test_full_list();
      for (int k = 0; k < CAP; k++) send_request(OP_PUSH_BACK, 0, $urandom);
      send_request(OP_PUSH_BACK, 0, 1);
      send_request(OP_PUSH_FRONT, 0, 1);
      send_request(OP_INSERT_AT, 8'hFF, 1);
      send_request(OP_READ_AT, 8'hFF, 0);
      send_request(OP_REMOVE_AT, 8'hFF, 0);
      send_request(OP_DELETE_ALL, 0, list_words[3]);
      drain_results();
      while (list_len > 0) send_request(OP_POP_FRONT, 0, 0);
   endtask

   task automatic test_back_pressure();
      hold_off = 1;
      for (int k = 0; k < 20; k++) send_request(OP_PUSH_BACK, 0, pick_value());
      drain_results();
   endtask

   task automatic test_random_ops();
      logic [3:0] op;
      logic [7:0] pos;
      for (int n = 0; n < 700; n++) begin
         if ($urandom_range(0, 49) == 0) op = 4'($urandom_range(10, 15));
         else if (list_len < 6 && $urandom_range(0, 1)) op = OP_PUSH_BACK;
         else op = 4'($urandom_range(0, 9));
         pos = ($urandom_range(0, 9) == 0) ? 8'($urandom)
               : 8'($urandom_range(0, list_len + 1));
         send_request(op, pos, pick_value());
      end
   endtask

   initial begin
      list_len = 0;
      hold_off = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_cases();
      test_each_operation();
      test_full_list();
      test_back_pressure();
      test_random_ops();
      drain_results();
      repeat (600) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("indexed_sequence_store_tb: PASS");
      else
         $display("indexed_sequence_store_tb: FAIL");
      $finish;
   end

endmodule

>>> indexed_sequence_store.f
sv/iss_pkg.sv
sv/iss_ctrl.sv
sv/iss_dp.sv
sv/indexed_sequence_store.sv
tb/indexed_sequence_store_tb.sv
